/* sv/b32sc_pkg.sv */
// Shared types, constants and alphabet functions for the base32 stream codec.
// No dependencies.
package b32sc_pkg;

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;
  localparam logic [7:0] PAD_CHAR    = 8'h3d;
  localparam logic [5:0] SYM_INVALID = 6'd32;

  typedef struct packed {
    logic [7:0] in_value;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_valid;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // 5-bit symbol to alphabet character
  function automatic logic [7:0] sym_to_char(input logic [4:0] v);
    logic [7:0] c;
    if (v < 5'd26) begin
      c = 8'h41 + {3'b000, v};
    end else begin
      c = 8'h18 + {3'b000, v};
    end
    return c;
  endfunction

  // character to symbol, SYM_INVALID when outside the alphabet
  function automatic logic [5:0] char_to_sym(input logic [7:0] c);
    logic [7:0] d;
    logic [5:0] s;
    s = SYM_INVALID;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      s = d[5:0];
    end else if (c >= 8'h32 && c <= 8'h37) begin
      d = c - 8'h18;
      s = d[5:0];
    end
    return s;
  endfunction

endpackage

/* sv/base32_stream_codec.sv */
// Base32 stream codec top level: input decode, message state and result sequencer.
// Depends on b32sc_pkg.
//
// Streaming Base32 (standard alphabet, '=' pad) encoder/decoder selected by the mode
// register; writing mode also clears the message state. Each accepted word is worked out
// combinationally into a small result group register, which then drains one result per
// cycle into the output register unless the output stalls. Encoding gives one or two
// characters per byte (eight per five bytes); the last byte of a message gives up to
// eight results (flush character and pads). Decoding gives at most one result per
// character and takes one word per cycle unless the output stalls. The next word is
// taken in the cycle the last result of the current group moves to the output register.
module base32_stream_codec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b32sc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b32sc_pkg::out_item_t out_data
);
  import b32sc_pkg::*;

  // configuration and message state
  logic        mode_r;
  logic [11:0] buf_r, buf_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic [2:0]  gpos_r, gpos_nxt;
  logic        pad_seen_r, pad_seen_nxt;
  logic        err_seen_r, err_seen_nxt;

  // result group
  logic [7:0]  grp_val_r [3];
  logic [7:0]  grp_val_nxt [3];
  logic [1:0]  grp_ndata_r, grp_ndata_nxt;
  logic [3:0]  grp_cnt_r, grp_cnt_nxt;
  logic [3:0]  grp_idx_r;
  logic        grp_last_r, grp_last_nxt;
  logic        grp_err_r, grp_err_nxt;
  logic        grp_enc_r;

  logic        out_valid_r;
  out_item_t   out_data_r, out_cur;

  logic        in_take, grp_busy, grp_take, grp_final;

  assign grp_busy  = grp_idx_r != grp_cnt_r;
  assign grp_take  = grp_busy && (!out_valid_r || out_ready);
  assign grp_final = grp_idx_r + 4'd1 == grp_cnt_r;
  assign in_ready  = !grp_busy || (grp_take && grp_final);
  assign in_take   = in_valid && in_ready;

  // per-word work
  always_comb begin
    logic [11:0] ebuf;
    logic [3:0]  etot, erem;
    logic [1:0]  en1;
    logic [4:0]  c0, c1, cf;
    logic [16:0] fl;
    logic [2:0]  gp_after, pads_need, pads_max, pads;
    logic [5:0]  sym;
    logic [11:0] dbuf;
    logic [3:0]  dtot, dsh;
    logic [11:0] dshift;
    logic        got_byte;

    buf_nxt       = buf_r;
    bcnt_nxt      = bcnt_r;
    gpos_nxt      = gpos_r;
    pad_seen_nxt  = pad_seen_r;
    err_seen_nxt  = err_seen_r;
    grp_val_nxt[0] = 8'h00;
    grp_val_nxt[1] = 8'h00;
    grp_val_nxt[2] = 8'h00;
    grp_ndata_nxt = 2'd0;
    grp_cnt_nxt   = 4'd0;
    grp_last_nxt  = in_data.in_last;
    grp_err_nxt   = 1'b0;

    // encode path
    ebuf = {buf_r[3:0], in_data.in_value};
    etot = bcnt_r + 4'd8;
    en1  = (etot >= 4'd10) ? 2'd2 : 2'd1;
    erem = (etot >= 4'd10) ? etot - 4'd10 : etot - 4'd5;
    c0   = 5'(ebuf >> (etot - 4'd5));
    c1   = 5'(ebuf >> (etot - 4'd10));
    fl   = {5'b00000, ebuf} << (4'd5 - erem);
    cf   = fl[4:0];

    // decode path
    sym      = char_to_sym(in_data.in_value);
    dbuf     = {buf_r[6:0], sym[4:0]};
    dtot     = bcnt_r + 4'd5;
    got_byte = dtot >= 4'd8;
    dsh      = got_byte ? dtot - 4'd8 : dtot;
    dshift   = dbuf >> dsh;

    gp_after  = 3'd0;
    pads_need = 3'd0;
    pads_max  = 3'd0;
    pads      = 3'd0;

    if (mode_r == MODE_ENCODE) begin
      grp_val_nxt[0] = sym_to_char(c0);
      if (en1 == 2'd2) begin
        grp_val_nxt[1] = sym_to_char(c1);
        grp_val_nxt[2] = sym_to_char(cf);
      end else begin
        grp_val_nxt[1] = sym_to_char(cf);
        grp_val_nxt[2] = sym_to_char(cf);
      end
      grp_ndata_nxt = en1 + {1'b0, (in_data.in_last && erem != 4'd0)};
      gp_after      = gpos_r + {1'b0, grp_ndata_nxt};
      if (in_data.in_last) begin
        // pad to a multiple of eight characters, at most eight results per word
        pads_need = 3'd0 - gp_after;
        pads_max  = 3'd0 - {1'b0, grp_ndata_nxt};
        pads      = (pads_need < pads_max) ? pads_need : pads_max;
        grp_cnt_nxt = {2'b00, grp_ndata_nxt} + {1'b0, pads};
      end else begin
        grp_cnt_nxt = {2'b00, grp_ndata_nxt};
      end
      buf_nxt  = ebuf;
      bcnt_nxt = erem;
      gpos_nxt = gp_after;
    end else begin
      if (!pad_seen_r) begin
        if (in_data.in_value == PAD_CHAR) begin
          pad_seen_nxt = 1'b1;
        end else if (sym == SYM_INVALID) begin
          err_seen_nxt = 1'b1;
        end else begin
          buf_nxt  = dbuf;
          bcnt_nxt = dsh;
          if (got_byte) begin
            grp_val_nxt[0] = dshift[7:0];
            grp_ndata_nxt  = 2'd1;
            grp_cnt_nxt    = 4'd1;
          end
        end
      end
      grp_err_nxt = err_seen_nxt;
      // end marker when the last word yields no byte
      if (in_data.in_last && grp_cnt_nxt == 4'd0) begin
        grp_cnt_nxt = 4'd1;
      end
    end

    if (in_data.in_last) begin
      buf_nxt      = 12'h000;
      bcnt_nxt     = 4'd0;
      gpos_nxt     = 3'd0;
      pad_seen_nxt = 1'b0;
      err_seen_nxt = 1'b0;
    end
  end

  // current result of the group
  always_comb begin
    logic [1:0] k;
    k = grp_idx_r[1:0];
    out_cur.out_error = grp_err_r;
    out_cur.out_last  = grp_last_r && grp_final;
    if (grp_idx_r < {2'b00, grp_ndata_r}) begin
      out_cur.out_value = grp_val_r[k];
      out_cur.out_valid = 1'b1;
    end else if (grp_enc_r) begin
      out_cur.out_value = PAD_CHAR;
      out_cur.out_valid = 1'b1;
    end else begin
      out_cur.out_value = 8'h00;
      out_cur.out_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ENCODE;
      buf_r       <= 12'h000;
      bcnt_r      <= 4'd0;
      gpos_r      <= 3'd0;
      pad_seen_r  <= 1'b0;
      err_seen_r  <= 1'b0;
      grp_cnt_r   <= 4'd0;
      grp_idx_r   <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r     <= cfg_wr_data;
        buf_r      <= 12'h000;
        bcnt_r     <= 4'd0;
        gpos_r     <= 3'd0;
        pad_seen_r <= 1'b0;
        err_seen_r <= 1'b0;
      end else if (in_take) begin
        buf_r      <= buf_nxt;
        bcnt_r     <= bcnt_nxt;
        gpos_r     <= gpos_nxt;
        pad_seen_r <= pad_seen_nxt;
        err_seen_r <= err_seen_nxt;
      end
      if (in_take) begin
        grp_cnt_r <= grp_cnt_nxt;
        grp_idx_r <= 4'd0;
      end else if (grp_take) begin
        grp_idx_r <= grp_idx_r + 4'd1;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= grp_take;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      grp_val_r   <= grp_val_nxt;
      grp_ndata_r <= grp_ndata_nxt;
      grp_last_r  <= grp_last_nxt;
      grp_err_r   <= grp_err_nxt;
      grp_enc_r   <= mode_r == MODE_ENCODE;
    end
    if (grp_take) begin
      out_data_r <= out_cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/tb_base32_stream_codec.sv */
// Self-checking bench for base32_stream_codec: directed table then random
// encode and decode messages, each result checked against a table entry or a local predictor.
// Depends on b32sc_pkg and base32_stream_codec.
`timescale 1ns / 1ps

module tb_base32_stream_codec;
  import b32sc_pkg::*;

  typedef struct packed {
    logic      wr;
    logic      mode;
    in_item_t  word;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = MODE_ENCODE;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int gap_pct = 30;
  int stall_pct = 56;
  int mismatches = 0;

  // predictor state
  logic        cur_mode;
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic [2:0]  group_pos;
  logic        pad_hit;
  logic        err_hit;

  out_item_t step_results[$];
  out_item_t pending_results[$];
  stim_row_t directed_rows[$];

  always #4 clk = ~clk;

  base32_stream_codec i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] b32_glyph(input logic [4:0] s);
    if (s < 5'd26) begin
      return 8'h41 + {3'b000, s};
    end
    return 8'h32 + {3'b000, s} - 8'd26;
  endfunction

  function automatic logic [5:0] b32_symbol(input logic [7:0] c);
    logic [7:0] d;
    d = 8'hff;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
    end else if (c >= 8'h32 && c <= 8'h37) begin
      d = c - 8'h32 + 8'd26;
    end
    if (d == 8'hff) begin
      return SYM_INVALID;
    end
    return d[5:0];
  endfunction

  function automatic void clear_message_state();
    acc_bits = '0;
    acc_count = '0;
    group_pos = '0;
    pad_hit = 1'b0;
    err_hit = 1'b0;
  endfunction

  // works out the results one accepted word causes, into step_results
  task automatic predict_codec(input in_item_t w);
    logic [11:0] shifted;
    logic [5:0]  sym;
    out_item_t   r;
    step_results.delete();
    if (cur_mode == MODE_ENCODE) begin
      acc_bits = {acc_bits[3:0], w.in_value};
      acc_count = acc_count + 4'd8;
      while (acc_count >= 4'd5) begin
        acc_count = acc_count - 4'd5;
        shifted = acc_bits >> acc_count;
        r = {b32_glyph(shifted[4:0]), 1'b1, 1'b0, 1'b0};
        step_results.push_back(r);
        group_pos = group_pos + 3'd1;
      end
      if (w.in_last) begin
        // zero-fill the partial group, then pad out to eight characters
        if (acc_count != 4'd0) begin
          shifted = acc_bits << (4'd5 - acc_count);
          r = {b32_glyph(shifted[4:0]), 1'b1, 1'b0, 1'b0};
          step_results.push_back(r);
          group_pos = group_pos + 3'd1;
        end
        while (group_pos != 3'd0 && step_results.size() < 8) begin
          r = {PAD_CHAR, 1'b1, 1'b0, 1'b0};
          step_results.push_back(r);
          group_pos = group_pos + 3'd1;
        end
      end
    end else begin
      if (!pad_hit) begin
        if (w.in_value == PAD_CHAR) begin
          pad_hit = 1'b1;
        end else begin
          sym = b32_symbol(w.in_value);
          if (sym == SYM_INVALID) begin
            err_hit = 1'b1;
          end else begin
            acc_bits = {acc_bits[6:0], sym[4:0]};
            acc_count = acc_count + 4'd5;
            if (acc_count >= 4'd8) begin
              acc_count = acc_count - 4'd8;
              shifted = acc_bits >> acc_count;
              r = {shifted[7:0], 1'b1, 1'b0, err_hit};
              step_results.push_back(r);
            end
          end
        end
      end
      if (w.in_last && step_results.size() == 0) begin
        r = {8'h00, 1'b0, 1'b0, err_hit};
        step_results.push_back(r);
      end
    end
    if (w.in_last) begin
      r = step_results.pop_back();
      r.out_last = 1'b1;
      step_results.push_back(r);
      clear_message_state();
    end
  endtask

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every expected word and for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
    clear_message_state();
  endtask

  task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want value %h valid %b last %b error %b,",
               $time, what, want.out_value, want.out_valid, want.out_last, want.out_error,
               " got value %h valid %b last %b error %b",
               got.out_value, got.out_valid, got.out_last, got.out_error);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_value !== want.out_value || out_data.out_valid !== want.out_valid ||
            out_data.out_last !== want.out_last || out_data.out_error !== want.out_error) begin
          flag_mismatch("wrong word", want, out_data);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    in_item_t    w;
    in_item_t    msg[$];
    logic [7:0]  ch;
    logic        m;
    int          ph, counted, len, kind, k, tail;

    cur_mode = MODE_ENCODE;
    clear_message_state();

    // encode: all-zero, all-one and other bytes, messages of one, two and five bytes
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'h00, 1'b1, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'hff, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'hff, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'hff, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'hff, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'hff, 1'b1, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'h66, 1'b1, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, PAD_CHAR, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_ENCODE, 8'h80, 1'b1, 1'b0, 11'h000});
    // decode: "MY" gives 0x66, then a pad alone closes with no data
    directed_rows.push_back({1'b1, MODE_DECODE, "M", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, "Y", 1'b0, 1'b1, {8'h66, 1'b1, 1'b0, 1'b0}});
    directed_rows.push_back({1'b0, MODE_DECODE, PAD_CHAR, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}});
    // anything after a pad is ignored, even a bad character
    directed_rows.push_back({1'b0, MODE_DECODE, "A", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, PAD_CHAR, 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, "!", 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}});
    // lowercase is outside the alphabet, error sticks to later bytes
    directed_rows.push_back({1'b0, MODE_DECODE, "a", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, "M", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, "Y", 1'b1, 1'b1, {8'h66, 1'b1, 1'b1, 1'b1}});
    directed_rows.push_back({1'b0, MODE_DECODE, 8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}});
    directed_rows.push_back({1'b0, MODE_DECODE, 8'hff, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}});
    directed_rows.push_back({1'b0, MODE_DECODE, "7", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b0, MODE_DECODE, "7", 1'b1, 1'b1, {8'hff, 1'b1, 1'b1, 1'b0}});
    // a mode write mid-message throws away the pending bits
    directed_rows.push_back({1'b0, MODE_DECODE, "M", 1'b0, 1'b0, 11'h000});
    directed_rows.push_back({1'b1, MODE_DECODE, "Y", 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.wr) begin
        settle();
        write_mode(row.mode);
      end
      send_word(row.word);
      predict_codec(row.word);
      if (row.typed) begin
        pending_results.push_back(row.want);
      end else begin
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 30 : (ph == 1) ? 56 : 0;
      stall_pct = (ph == 0) ? 56 : (ph == 1) ? 30 : 0;
      counted = 0;
      while (counted < 45) begin
        m = 1'($urandom_range(1));
        if (m != cur_mode || $urandom_range(5) == 0) begin
          settle();
          write_mode(m);
        end
        msg.delete();
        if (m == MODE_ENCODE) begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len; k++) begin
            ch = 8'($urandom_range(255));
            if ($urandom_range(7) == 0) ch = $urandom_range(1) ? 8'hff : 8'h00;
            msg.push_back({ch, 1'b0});
          end
        end else begin
          kind = $urandom_range(9);
          len  = $urandom_range(1, 16);
          for (k = 0; k < len; k++) begin
            if (kind == 9) begin
              ch = 8'($urandom_range(255));
            end else begin
              ch = b32_glyph(5'($urandom_range(31)));
              if (kind == 8 && $urandom_range(3) == 0) begin
                ch = 8'($urandom_range(255));
                while (b32_symbol(ch) != SYM_INVALID || ch == PAD_CHAR) begin
                  ch = 8'($urandom_range(255));
                end
              end
            end
            msg.push_back({ch, 1'b0});
          end
          // well-formed tail: pads up to a whole group
          if (kind <= 3) begin
            while (msg.size() % 8 != 0) msg.push_back({PAD_CHAR, 1'b0});
          end
          if (kind == 7) begin
            msg.push_back({PAD_CHAR, 1'b0});
            tail = $urandom_range(1, 4);
            for (k = 0; k < tail; k++) begin
              ch = 8'($urandom_range(255));
              msg.push_back({ch, 1'b0});
            end
          end
        end
        w = msg.pop_back();
        w.in_last = 1'b1;
        msg.push_back(w);
        counted += msg.size();
        foreach (msg[j]) begin
          send_word(msg[j]);
          predict_codec(msg[j]);
          foreach (step_results[n]) pending_results.push_back(step_results[n]);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
